// ===== rtl/core/lom_pkg.sv =====
`timescale 1ns / 1ps
package lom_pkg;

  localparam int SIDE_W    = 1;
  localparam int PROD_W    = 4;
  localparam int TRD_W     = 3;
  localparam int ID_W      = 20;
  localparam int PRICE_W   = 20;
  localparam int QTY_W     = 20;
  localparam int VAL_W     = 40;
  localparam int FEE_W     = 34;
  localparam int ARR_W     = 32;
  localparam int UNITS_W   = 32;
  localparam int CASH_W    = 64;
  localparam int FEE_TOT_W = 64;
  localparam int DIV_REM_W = 7;
  localparam int DIG_W     = 8;
  localparam int DIV_STEPS = VAL_W / DIG_W;
  localparam int DIV_CNT_W = 3;
  localparam int TRIAL_W   = DIV_REM_W + DIG_W;
  localparam int RECIP_W   = 13;
  localparam int RCP_PROD_W = TRIAL_W + RECIP_W;
  // floor(v * 5243 / 2^19) equals floor(v / 100) for every v below 2^15
  localparam logic [RECIP_W-1:0] FEE_RECIP    = 13'd5243;
  localparam int                 FEE_RECIP_SH = 19;
  localparam logic [TRIAL_W-1:0] FEE_DIVISOR  = 15'd100;
  localparam logic [VAL_W-1:0]   FEE_ROUND    = 40'd50;

  typedef enum logic [1:0] {
    KIND_FILL   = 2'd0,
    KIND_RESTED = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  typedef struct packed {
    logic [SIDE_W-1:0]  side;
    logic [PROD_W-1:0]  product;
    logic [TRD_W-1:0]   trader;
    logic [ID_W-1:0]    order_ref;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } order_t;

  typedef struct packed {
    logic [SIDE_W-1:0]  side;
    logic [PROD_W-1:0]  product;
    logic [TRD_W-1:0]   trader;
    logic [ID_W-1:0]    order_ref;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [ARR_W-1:0]   arrival;
  } entry_t;

  typedef struct packed {
    kind_t              kind;
    logic [ID_W-1:0]    resting_ref;
    logic [TRD_W-1:0]   resting_trader;
    logic [QTY_W-1:0]   fill_qty;
    logic [VAL_W-1:0]   trade_value;
    logic [FEE_W-1:0]   trade_fee;
    logic [QTY_W-1:0]   remaining_qty;
    logic               last;
  } result_t;

  // head of the order queue, front to back
  typedef struct packed {
    logic   valid;
    order_t order;
  } q_head_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_FEE_SET,
    ST_DIV,
    ST_BOOK,
    ST_PRD_N,
    ST_PWR_N,
    ST_PRD_R,
    ST_PWR_R,
    ST_EMIT,
    ST_FINAL
  } back_state_t;

endpackage

// ===== rtl/core/lom_if.sv =====
`timescale 1ns / 1ps
interface lom_in_if;
  logic        valid;
  logic        ready;
  logic        side;
  logic [3:0]  product;
  logic [2:0]  trader;
  logic [19:0] order_ref;
  logic [19:0] price;
  logic [19:0] qty;
  modport source(output valid, side, product, trader, order_ref, price, qty, input ready);
  modport sink(input valid, side, product, trader, order_ref, price, qty, output ready);
endinterface

interface lom_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [19:0] resting_ref;
  logic [2:0]  resting_trader;
  logic [19:0] fill_qty;
  logic [39:0] trade_value;
  logic [33:0] trade_fee;
  logic [19:0] remaining_qty;
  logic        last;
  modport source(output valid, kind, resting_ref, resting_trader, fill_qty,
                 trade_value, trade_fee, remaining_qty, last, input ready);
  modport sink(input valid, kind, resting_ref, resting_trader, fill_qty,
               trade_value, trade_fee, remaining_qty, last, output ready);
endinterface

// ===== rtl/core/lom_front.sv =====
`timescale 1ns / 1ps
module lom_front #(
  parameter int TRADER_COUNT  = 8,
  parameter int PRODUCT_COUNT = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  lom_in_if.sink           in_ch,
  input  logic             busy,
  input  logic             pop,
  output lom_pkg::q_head_t head
);
  import lom_pkg::*;

  order_t     fifo_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  order_t     cls;

  // reduce indexes beyond the configured counts
  function automatic logic [PROD_W-1:0] red_prod(input logic [PROD_W-1:0] x);
    logic [PROD_W-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << PROD_W); i++) begin
      if (x == PROD_W'(i)) r = PROD_W'(i % PRODUCT_COUNT);
    end
    return r;
  endfunction

  function automatic logic [TRD_W-1:0] red_trd(input logic [TRD_W-1:0] x);
    logic [TRD_W-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << TRD_W); i++) begin
      if (x == TRD_W'(i)) r = TRD_W'(i % TRADER_COUNT);
    end
    return r;
  endfunction

  assign in_ch.ready = !busy && (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    cls.side      = in_ch.side;
    cls.product   = red_prod(in_ch.product);
    cls.trader    = red_trd(in_ch.trader);
    cls.order_ref = in_ch.order_ref;
    cls.price     = in_ch.price;
    cls.qty       = in_ch.qty;
  end

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= cls;
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.order = fifo_r[rd_ptr_r];

endmodule

// ===== rtl/core/lom_back.sv =====
`timescale 1ns / 1ps
module lom_back #(
  parameter int BOOK_DEPTH    = 32,
  parameter int TRADER_COUNT  = 8,
  parameter int PRODUCT_COUNT = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lom_pkg::q_head_t head,
  output logic             pop,
  output logic             busy,
  lom_out_if.source        out_ch
);
  import lom_pkg::*;

  localparam int BIW  = $clog2(BOOK_DEPTH);
  localparam int BCW  = $clog2(BOOK_DEPTH + 1);
  localparam int NPOS = TRADER_COUNT * PRODUCT_COUNT;
  localparam int PIW  = (NPOS > 1) ? $clog2(NPOS) : 1;

  back_state_t state_r, state_nxt;

  entry_t                 book_mem [BOOK_DEPTH];
  logic [BOOK_DEPTH-1:0]  bvalid_r;
  logic [UNITS_W+CASH_W-1:0] pos_mem [NPOS];
  logic [UNITS_W+CASH_W-1:0] pos_q;

  order_t            ord_r;
  logic [QTY_W-1:0]  rem_r;
  logic [BCW-1:0]    scan_r;
  entry_t            rd_q;
  logic [BIW-1:0]    rd_idx_r;
  logic              rd_vld_r;
  entry_t            best_r;
  logic [BIW-1:0]    best_idx_r;
  logic              best_fnd_r;
  logic [ARR_W-1:0]  arr_cnt_r;
  logic [FEE_TOT_W-1:0] fee_total_r;
  logic [QTY_W-1:0]  fq_r;
  logic [VAL_W-1:0]  val_r;
  logic [VAL_W-1:0]  dvd_r;
  logic [DIV_REM_W-1:0] drem_r;
  logic [FEE_W-1:0]  fee_r;
  logic [DIV_CNT_W-1:0] dcnt_r;
  logic [PIW-1:0]    clr_r;
  logic              out_vld_r;
  result_t           out_r;

  logic              out_free, cand, better, take, scan_done, issue;
  logic [QTY_W-1:0]  fq;
  logic [TRIAL_W-1:0]    trial;
  logic [RCP_PROD_W-1:0] recip;
  logic [DIG_W-1:0]      qdig;
  logic [DIV_REM_W-1:0]  rdig;
  logic [PIW-1:0]    idx_n, idx_r, pos_raddr;
  logic              pos_we;
  logic [PIW-1:0]    pos_waddr;
  logic [UNITS_W-1:0] du_n, du_r;
  logic [CASH_W-1:0]  dc_n, dc_r;
  logic [UNITS_W+CASH_W-1:0] pos_wdata;
  logic [BIW-1:0]    free_idx;
  logic              free_fnd;
  logic              load_fill, load_final, rest_wr;

  assign busy     = (state_r == ST_CLEAR);
  assign out_free = !out_vld_r || out_ch.ready;
  assign issue    = (scan_r < BCW'(BOOK_DEPTH));
  assign scan_done = !issue && !rd_vld_r;
  assign fq       = (rem_r < best_r.qty) ? rem_r : best_r.qty;

  // one radix-256 digit of the fee divide per cycle, quotient by reciprocal
  assign trial = {drem_r, dvd_r[VAL_W-1 -: DIG_W]};
  assign recip = RCP_PROD_W'(trial) * RCP_PROD_W'(FEE_RECIP);
  assign qdig  = DIG_W'(recip >> FEE_RECIP_SH);
  assign rdig  = DIV_REM_W'(trial - TRIAL_W'(qdig) * FEE_DIVISOR);

  assign idx_n = PIW'(int'(ord_r.trader) * PRODUCT_COUNT + int'(ord_r.product));
  assign idx_r = PIW'(int'(best_r.trader) * PRODUCT_COUNT + int'(ord_r.product));

  // candidate check on the entry read last cycle
  always_comb begin
    cand = rd_vld_r && bvalid_r[rd_idx_r] && (rd_q.side != ord_r.side) &&
           (rd_q.product == ord_r.product) &&
           ((ord_r.side == 1'b0) ? (rd_q.price <= ord_r.price)
                                 : (rd_q.price >= ord_r.price));
    better = !best_fnd_r ||
             ((ord_r.side == 1'b0) ? (rd_q.price < best_r.price)
                                   : (rd_q.price > best_r.price)) ||
             ((rd_q.price == best_r.price) &&
              ((arr_cnt_r - rd_q.arrival) > (arr_cnt_r - best_r.arrival)));
    take = cand && better;
  end

  always_comb begin
    free_idx = '0;
    free_fnd = 1'b0;
    for (int i = BOOK_DEPTH - 1; i >= 0; i--) begin
      if (!bvalid_r[i]) begin
        free_idx = BIW'(i);
        free_fnd = 1'b1;
      end
    end
  end

  // position deltas
  always_comb begin
    if (ord_r.side == 1'b0) begin
      du_n = UNITS_W'(fq_r);
      dc_n = '0 - (CASH_W'(val_r) + CASH_W'(fee_r));
      du_r = '0 - UNITS_W'(fq_r);
      dc_r = CASH_W'(val_r);
    end else begin
      du_n = '0 - UNITS_W'(fq_r);
      dc_n = CASH_W'(val_r) - CASH_W'(fee_r);
      du_r = UNITS_W'(fq_r);
      dc_r = '0 - CASH_W'(val_r);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    pop        = 1'b0;
    pos_we     = 1'b0;
    pos_waddr  = idx_n;
    pos_wdata  = '0;
    pos_raddr  = idx_n;
    load_fill  = 1'b0;
    load_final = 1'b0;
    rest_wr    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        pos_we    = 1'b1;
        pos_waddr = clr_r;
        if (clr_r == PIW'(NPOS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (head.valid) begin
          pop       = 1'b1;
          state_nxt = (head.order.qty == '0) ? ST_FINAL : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) state_nxt = best_fnd_r ? ST_MUL : ST_FINAL;
      end
      ST_MUL:     state_nxt = ST_FEE_SET;
      ST_FEE_SET: state_nxt = ST_DIV;
      ST_DIV: begin
        if (dcnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = ST_BOOK;
      end
      ST_BOOK:  state_nxt = ST_PRD_N;
      ST_PRD_N: state_nxt = ST_PWR_N;
      ST_PWR_N: begin
        pos_we    = 1'b1;
        pos_wdata = {pos_q[UNITS_W+CASH_W-1:CASH_W] + du_n, pos_q[CASH_W-1:0] + dc_n};
        state_nxt = ST_PRD_R;
      end
      ST_PRD_R: begin
        pos_raddr = idx_r;
        state_nxt = ST_PWR_R;
      end
      ST_PWR_R: begin
        pos_we    = 1'b1;
        pos_waddr = idx_r;
        pos_wdata = {pos_q[UNITS_W+CASH_W-1:CASH_W] + du_r, pos_q[CASH_W-1:0] + dc_r};
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          load_fill = 1'b1;
          state_nxt = (rem_r != '0) ? ST_SCAN : ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          load_final = 1'b1;
          rest_wr    = (rem_r != '0) && free_fnd;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      bvalid_r    <= '0;
      arr_cnt_r   <= '0;
      fee_total_r <= '0;
      out_vld_r   <= 1'b0;
      rd_vld_r    <= 1'b0;
      best_fnd_r  <= 1'b0;
      scan_r      <= '0;
    end else begin
      if (state_r == ST_CLEAR) clr_r <= clr_r + PIW'(1);
      out_vld_r <= load_fill || load_final || (out_vld_r && !out_ch.ready);
      if ((state_nxt == ST_SCAN) && (state_r != ST_SCAN)) begin
        scan_r     <= '0;
        rd_vld_r   <= 1'b0;
        best_fnd_r <= 1'b0;
      end else if (state_r == ST_SCAN) begin
        rd_vld_r <= issue;
        if (issue) scan_r <= scan_r + BCW'(1);
        if (take)  best_fnd_r <= 1'b1;
      end
      if ((state_r == ST_BOOK) && (best_r.qty == fq_r)) bvalid_r[best_idx_r] <= 1'b0;
      if (state_r == ST_BOOK) fee_total_r <= fee_total_r + FEE_TOT_W'(fee_r);
      if (rest_wr) begin
        bvalid_r[free_idx] <= 1'b1;
        arr_cnt_r          <= arr_cnt_r + ARR_W'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      ord_r <= head.order;
      rem_r <= head.order.qty;
    end
    if (state_r == ST_SCAN) begin
      rd_idx_r <= scan_r[BIW-1:0];
      if (take) begin
        best_r     <= rd_q;
        best_idx_r <= rd_idx_r;
      end
    end
    if (state_r == ST_MUL) begin
      fq_r  <= fq;
      val_r <= VAL_W'(fq) * VAL_W'(best_r.price);
    end
    if (state_r == ST_FEE_SET) begin
      dvd_r  <= val_r + FEE_ROUND;
      drem_r <= '0;
      dcnt_r <= '0;
      fee_r  <= '0;
    end
    if (state_r == ST_DIV) begin
      dvd_r  <= {dvd_r[VAL_W-DIG_W-1:0], {DIG_W{1'b0}}};
      dcnt_r <= dcnt_r + DIV_CNT_W'(1);
      drem_r <= rdig;
      fee_r  <= {fee_r[FEE_W-DIG_W-1:0], qdig};
    end
    if (state_r == ST_BOOK) begin
      rem_r      <= rem_r - fq_r;
      best_r.qty <= best_r.qty - fq_r;
    end
    if (load_fill) begin
      out_r.kind             <= KIND_FILL;
      out_r.resting_ref      <= best_r.order_ref;
      out_r.resting_trader   <= best_r.trader;
      out_r.fill_qty         <= fq_r;
      out_r.trade_value      <= val_r;
      out_r.trade_fee        <= fee_r;
      out_r.remaining_qty    <= rem_r;
      out_r.last             <= 1'b0;
    end
    if (load_final) begin
      priority if (rem_r == '0) out_r.kind <= KIND_DONE;
      else if (free_fnd)        out_r.kind <= KIND_RESTED;
      else                      out_r.kind <= KIND_REJECT;
      out_r.resting_ref      <= '0;
      out_r.resting_trader   <= '0;
      out_r.fill_qty         <= '0;
      out_r.trade_value      <= '0;
      out_r.trade_fee        <= '0;
      out_r.remaining_qty    <= rem_r;
      out_r.last             <= 1'b1;
    end
  end

  // book memory: one read port for the scan, one write port
  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN && issue) rd_q <= book_mem[scan_r[BIW-1:0]];
    if (state_r == ST_PRD_N) begin
      book_mem[best_idx_r] <= best_r;
    end else if (rest_wr) begin
      book_mem[free_idx] <= '{side: ord_r.side, product: ord_r.product,
                              trader: ord_r.trader, order_ref: ord_r.order_ref,
                              price: ord_r.price, qty: rem_r, arrival: arr_cnt_r};
    end
  end

  // position memory
  always_ff @(posedge clk) begin
    pos_q <= pos_mem[pos_raddr];
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.kind             = out_r.kind;
  assign out_ch.resting_ref      = out_r.resting_ref;
  assign out_ch.resting_trader   = out_r.resting_trader;
  assign out_ch.fill_qty         = out_r.fill_qty;
  assign out_ch.trade_value      = out_r.trade_value;
  assign out_ch.trade_fee        = out_r.trade_fee;
  assign out_ch.remaining_qty    = out_r.remaining_qty;
  assign out_ch.last             = out_r.last;

endmodule

// ===== rtl/core/limit_order_matching_engine.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake      Transaction
// in_ch     in   valid/ready    one new limit order
// out_ch    out  valid/ready    one fill, or the closing status of an order
//
// Flow: an order is popped, scanned against the book one entry a cycle (skipped
// for a zero quantity), then closed. Each fill adds a multiply, a round, a
// five-step radix-256 fee divide, a book update, a position-table read and write
// for each trader and an emit, plus a rescan. Reset: clear control state, then
// zero the position table with in_ch.ready low. Stalls: a two-entry queue takes
// orders while the matcher works; hold results while out_ch stalls.
module limit_order_matching_engine #(
  parameter int BOOK_DEPTH    = 32,
  parameter int TRADER_COUNT  = 8,
  parameter int PRODUCT_COUNT = 16
) (
  input logic       clk,
  input logic       rst_n,
  lom_in_if.sink    in_ch,
  lom_out_if.source out_ch
);
  import lom_pkg::*;

  q_head_t head;
  logic    pop;
  logic    busy;

  // front: classify and queue incoming orders
  lom_front #(
    .TRADER_COUNT (TRADER_COUNT),
    .PRODUCT_COUNT(PRODUCT_COUNT)
  ) u_front (
    .clk  (clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .busy (busy),
    .pop  (pop),
    .head (head)
  );

  // back: match against the book, update positions, emit results
  lom_back #(
    .BOOK_DEPTH   (BOOK_DEPTH),
    .TRADER_COUNT (TRADER_COUNT),
    .PRODUCT_COUNT(PRODUCT_COUNT)
  ) u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .head  (head),
    .pop   (pop),
    .busy  (busy),
    .out_ch(out_ch)
  );

  // never drain an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid) else $error("pop from empty queue");

  // no transaction is taken while the position table is being cleared
  a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ch.ready) else $error("input taken during clear");

  // fills never close an order; closing results carry no trade
  a_fill_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == KIND_FILL) |-> !out_ch.last)
    else $error("fill marked last");

  a_close_no_trade: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last) |-> (out_ch.fill_qty == '0 && out_ch.trade_fee == '0))
    else $error("closing result carries a trade");

endmodule
